// ----- design/msb_first_bit_packer_crc24q_macros.svh -----
// ----------------------------------------------------------------------------
// MSB-first bit packer assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_PACKER_CRC24Q_MACROS_SVH
`define MSB_FIRST_BIT_PACKER_CRC24Q_MACROS_SVH

// same-cycle implication
`define MSBP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/msbp_pkg.sv -----
// ----------------------------------------------------------------------------
// MSB-first bit packer package
// Field widths, mode codes, CRC-24Q constants and shared control types.
// ----------------------------------------------------------------------------
`default_nettype none

package msbp_pkg;

  localparam int MODE_W    = 3;
  localparam int FWIDTH_W  = 7;
  localparam int FVALUE_W  = 64;
  localparam int BYTE_BITS = 8;
  localparam int POS_W     = 3;
  localparam int CRC_BITS  = 24;
  localparam int MAX_FIELD_BITS_DEF = 64;

  localparam logic [CRC_BITS-1:0] CRC_POLY = 24'h864CFB;

  localparam logic [MODE_W-1:0] MODE_UNSIGNED = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SIGNED   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RAW      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CRC      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_END      = 3'd4;

  typedef struct packed {
    logic en;
    logic clr;
    logic load;
    logic din;
  } crc_ctl_t;

  typedef struct packed {
    logic en;
    logic clr;
    logic din;
  } pack_ctl_t;

  typedef struct packed {
    logic                 done;
    logic [BYTE_BITS-1:0] data;
    logic [POS_W-1:0]     pos;
  } pack_sts_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    logic                 byte_valid;
    logic                 frame_end;
    logic                 last_of_run;
  } res_t;

endpackage

`default_nettype wire

// ----- design/msbp_if.sv -----
// ----------------------------------------------------------------------------
// MSB-first bit packer channels
// Valid/ready channels for the field beats and the byte result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface msbp_in_if;
  logic                          valid;
  logic                          ready;
  logic [msbp_pkg::MODE_W-1:0]   mode;
  logic [msbp_pkg::FWIDTH_W-1:0] field_width;
  logic [msbp_pkg::FVALUE_W-1:0] field_value;

  modport source (output valid, output mode, output field_width, output field_value,
                  input ready);
  modport sink (input valid, input mode, input field_width, input field_value,
                output ready);
endinterface

interface msbp_out_if;
  logic                           valid;
  logic                           ready;
  logic [msbp_pkg::BYTE_BITS-1:0] out_byte;
  logic                           byte_valid;
  logic                           frame_end;
  logic                           last_of_run;

  modport source (output valid, output out_byte, output byte_valid, output frame_end,
                  output last_of_run, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input frame_end,
                input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- design/msbp_crc.sv -----
// ----------------------------------------------------------------------------
// Bit-serial CRC-24Q register
// Absorbs one bit per cycle while en is high, MSB first; clear, load and advance controls.
// ----------------------------------------------------------------------------
`default_nettype none

module msbp_crc (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire msbp_pkg::crc_ctl_t            ctl_i,
  input  wire logic [msbp_pkg::CRC_BITS-1:0] load_i,
  output logic [msbp_pkg::CRC_BITS-1:0]      crc_o
);

  logic [msbp_pkg::CRC_BITS-1:0] crc_q, crc_d;
  logic                          fb;

  assign fb = crc_q[msbp_pkg::CRC_BITS-1] ^ ctl_i.din;

  always_comb begin
    crc_d = crc_q;
    if (ctl_i.clr) begin
      crc_d = '0;
    end else if (ctl_i.load) begin
      crc_d = load_i;
    end else if (ctl_i.en) begin
      crc_d = {crc_q[msbp_pkg::CRC_BITS-2:0], 1'b0} ^ (fb ? msbp_pkg::CRC_POLY : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

`default_nettype wire

// ----- design/msbp_packer.sv -----
// ----------------------------------------------------------------------------
// Partial byte packer
// Places one bit per cycle while en is high, MSB first, and flags the completed byte.
// ----------------------------------------------------------------------------
`default_nettype none

module msbp_packer (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire msbp_pkg::pack_ctl_t ctl_i,
  output msbp_pkg::pack_sts_t      sts_o
);

  localparam logic [msbp_pkg::POS_W-1:0] PosLast = msbp_pkg::POS_W'(msbp_pkg::BYTE_BITS - 1);

  logic [msbp_pkg::BYTE_BITS-1:0] partial_q, partial_d;
  logic [msbp_pkg::POS_W-1:0]     pos_q, pos_d;
  logic [msbp_pkg::BYTE_BITS-1:0] merged;
  logic                           done;

  always_comb begin
    merged = partial_q;
    merged[PosLast - pos_q] = ctl_i.din;
  end

  assign done = ctl_i.en && (pos_q == PosLast);

  always_comb begin
    partial_d = partial_q;
    pos_d     = pos_q;
    if (ctl_i.clr || done) begin
      partial_d = '0;
      pos_d     = '0;
    end else if (ctl_i.en) begin
      partial_d = merged;
      pos_d     = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      pos_q     <= '0;
    end else begin
      partial_q <= partial_d;
      pos_q     <= pos_d;
    end
  end

  assign sts_o = {done, merged, pos_q};

endmodule

`default_nettype wire

// ----- design/msbp_out_reg.sv -----
// ----------------------------------------------------------------------------
// Result output register
// Holds one result beat for the sink and reports when a new one may enter.
// ----------------------------------------------------------------------------
`default_nettype none

module msbp_out_reg (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire msbp_pkg::res_t  res_i,
  output logic                 go_o,
  msbp_out_if.source           out_o
);

  logic           valid_q;
  msbp_pkg::res_t data_q;

  assign go_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i && go_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && go_o) begin
      data_q <= res_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.out_byte    = data_q.out_byte;
  assign out_o.byte_valid  = data_q.byte_valid;
  assign out_o.frame_end   = data_q.frame_end;
  assign out_o.last_of_run = data_q.last_of_run;

endmodule

`default_nettype wire

// ----- design/msb_first_bit_packer_crc24q.sv -----
// ----------------------------------------------------------------------------
// MSB-first bit packer with CRC-24Q
// Packs 1..MAX_FIELD_BITS bit fields into bytes, with raw bytes, checksum
// and frame end commands.
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   mode, field_width, field_value
//   out_o    out  valid/ready   out_byte, byte_valid, frame_end, last_of_run
//
// One bit per cycle through the packer and CRC register while out_o does not
// stall: a field beat shifts field_width bits, a raw byte pads, then shifts 8,
// a checksum runs the pad through a CRC copy, then shifts 24; an end frame
// pads or sends an empty beat. Pad is 8 minus the bit count, none at 0 bits.
// in_i is ready only between beats; the engine holds while out_o stalls, except that the checksum pad runs on.
// Reset clears the partial byte, the bit count and the CRC at once.
// ----------------------------------------------------------------------------
`default_nettype none
`include "msb_first_bit_packer_crc24q_macros.svh"

module msb_first_bit_packer_crc24q #(
  parameter int MAX_FIELD_BITS = msbp_pkg::MAX_FIELD_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  msbp_in_if.sink    in_i,
  msbp_out_if.source out_o
);

  localparam int SrcW = (MAX_FIELD_BITS > msbp_pkg::CRC_BITS) ? MAX_FIELD_BITS
                                                               : msbp_pkg::CRC_BITS;
  localparam int CntW = $clog2(SrcW + 1);
  localparam int IdxW = $clog2(SrcW);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_CRCZ  = 3'd2;
  localparam logic [2:0] ST_SHIFT = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  logic [2:0]                    state_q, state_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [SrcW-1:0]               src_q, src_d;
  logic [msbp_pkg::MODE_W-1:0]   mode_q, mode_d;

  msbp_pkg::crc_ctl_t            live_ctl, tmp_ctl;
  msbp_pkg::pack_ctl_t           pack_ctl;
  msbp_pkg::pack_sts_t           pack_sts;
  msbp_pkg::res_t                res;
  logic [msbp_pkg::CRC_BITS-1:0] live_crc, tmp_crc;
  logic                          push, go, step, in_accept, is_end;
  logic [CntW-1:0]               w_sat;
  logic [SrcW-1:0]               field_src;
  logic [IdxW-1:0]               idx;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;
  assign step       = go && (state_q != ST_IDLE);
  assign is_end     = (mode_q == msbp_pkg::MODE_END);
  assign idx        = IdxW'(cnt_q - CntW'(1));

  always_comb begin
    if (32'(in_i.field_width) > 32'(MAX_FIELD_BITS)) begin
      w_sat = CntW'(MAX_FIELD_BITS);
    end else begin
      w_sat = CntW'(in_i.field_width);
    end
  end

  always_comb begin
    field_src = SrcW'(in_i.field_value[MAX_FIELD_BITS-1:0]);
    if (in_i.mode == msbp_pkg::MODE_SIGNED && w_sat != '0) begin
      field_src[IdxW'(w_sat - CntW'(1))] = in_i.field_value[msbp_pkg::FVALUE_W-1];
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    src_d    = src_q;
    mode_d   = mode_q;
    live_ctl = '0;
    tmp_ctl  = '0;
    pack_ctl = '0;
    push     = 1'b0;
    res      = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          mode_d = in_i.mode;
          case (in_i.mode)
            msbp_pkg::MODE_UNSIGNED, msbp_pkg::MODE_SIGNED: begin
              if (w_sat != '0) begin
                src_d   = field_src;
                cnt_d   = w_sat;
                state_d = ST_SHIFT;
              end
            end
            msbp_pkg::MODE_RAW: begin
              src_d   = SrcW'(in_i.field_value[msbp_pkg::BYTE_BITS-1:0]);
              cnt_d   = CntW'(msbp_pkg::BYTE_BITS);
              state_d = (pack_sts.pos != '0) ? ST_PAD : ST_SHIFT;
            end
            msbp_pkg::MODE_CRC: begin
              tmp_ctl.load = 1'b1;
              cnt_d   = (pack_sts.pos == '0) ? '0
                        : CntW'(msbp_pkg::BYTE_BITS) - CntW'(pack_sts.pos);
              state_d = ST_CRCZ;
            end
            msbp_pkg::MODE_END: begin
              state_d = (pack_sts.pos != '0) ? ST_PAD : ST_EMPTY;
            end
            default: ;
          endcase
        end
      end
      ST_PAD: begin
        if (go) begin
          pack_ctl.en = 1'b1;
          live_ctl.en = 1'b1;
          if (pack_sts.done) begin
            push            = 1'b1;
            res.out_byte    = pack_sts.data;
            res.byte_valid  = 1'b1;
            res.frame_end   = is_end;
            res.last_of_run = is_end;
            live_ctl.clr    = is_end;
            state_d         = is_end ? ST_IDLE : ST_SHIFT;
          end
        end
      end
      ST_CRCZ: begin
        if (cnt_q == '0) begin
          src_d   = SrcW'(tmp_crc);
          cnt_d   = CntW'(msbp_pkg::CRC_BITS);
          state_d = ST_SHIFT;
        end else begin
          tmp_ctl.en = 1'b1;
          cnt_d      = cnt_q - CntW'(1);
        end
      end
      ST_SHIFT: begin
        if (go) begin
          pack_ctl.en  = 1'b1;
          pack_ctl.din = src_q[idx];
          live_ctl.en  = 1'b1;
          live_ctl.din = src_q[idx];
          if (pack_sts.done) begin
            push            = 1'b1;
            res.out_byte    = pack_sts.data;
            res.byte_valid  = 1'b1;
            res.last_of_run = (cnt_q <= CntW'(msbp_pkg::BYTE_BITS));
          end
          cnt_d = cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMPTY: begin
        if (go) begin
          push            = 1'b1;
          res.frame_end   = 1'b1;
          res.last_of_run = 1'b1;
          pack_ctl.clr    = 1'b1;
          live_ctl.clr    = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      mode_q  <= msbp_pkg::MODE_UNSIGNED;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      mode_q  <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
  end

  msbp_packer u_packer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (pack_ctl),
    .sts_o  (pack_sts)
  );

  msbp_crc u_live_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (live_ctl),
    .load_i ('0),
    .crc_o  (live_crc)
  );

  msbp_crc u_tmp_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (tmp_ctl),
    .load_i (live_crc),
    .crc_o  (tmp_crc)
  );

  msbp_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .res_i  (res),
    .go_o   (go),
    .out_o  (out_o)
  );

  `MSBP_ASSERT_SAME(a_end_is_last, push && res.frame_end, res.last_of_run, "frame end not last")
  `MSBP_ASSERT_SAME(a_empty_only_end, push && !res.byte_valid, res.frame_end, "empty beat mid frame")
  `MSBP_ASSERT_NEXT(a_end_clears, push && res.frame_end, live_crc == '0 && pack_sts.pos == '0, "state kept after frame end")
  `MSBP_ASSERT_NEXT(a_bad_mode_idle, in_accept && in_i.mode > msbp_pkg::MODE_END, state_q == ST_IDLE, "unknown mode started work")
  `MSBP_ASSERT_SAME(a_hold_on_stall, out_o.valid && !out_o.ready, !step && !push, "engine advanced on stall")

endmodule

`default_nettype wire

// ----- tb/sv/tb_msb_first_bit_packer_crc24q.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MSB-first bit packer testbench
// Feeds field, raw byte, checksum and end frame beats through valid/ready
// with random idle bursts on both channels. Each accepted input beat is
// packed by a local model of the packer and its CRC-24Q; every output beat
// is checked field by field against the oldest predicted byte.
// ----------------------------------------------------------------------------
module tb_msb_first_bit_packer_crc24q;
  import msbp_pkg::*;

  localparam int FIELD_BITS_MAX   = MAX_FIELD_BITS_DEF;
  localparam int STIM_BEATS       = 268;
  localparam int TAIL_BEATS       = 40;
  localparam int LONG_HOLD_AT     = 80;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int PAUSE_BEAT       = 150;
  localparam int DRAIN_CYCLES     = 120;
  localparam int MAX_REPORTS      = 10;

  localparam logic [MODE_W-1:0] MODE_RSVD_LO  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD_MID = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD_HI  = 3'd7;

  typedef struct {
    logic [MODE_W-1:0]   mode;
    logic [FWIDTH_W-1:0] width;
    logic [FVALUE_W-1:0] value;
    bit                  hold_first;
  } field_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  msbp_in_if  in_if ();
  msbp_out_if out_if ();

  msb_first_bit_packer_crc24q #(
    .MAX_FIELD_BITS(FIELD_BITS_MAX)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  field_beat_t pend_q[$];
  res_t        byte_exp_q[$];
  res_t        beat_res_q[$];

  logic [BYTE_BITS-1:0] pk_byte;
  logic [POS_W-1:0]     pk_pos;
  logic [CRC_BITS-1:0]  pk_crc;

  int unsigned beats_taken;
  int unsigned send_gap;
  int unsigned stall_cnt;
  int unsigned long_hold_cnt;
  bit          long_hold_done;
  bit          quiet_tail;
  int          err_cnt;
  int          stim_total;

  // ---------------------------------------------------------------- packer model
  function automatic logic [CRC_BITS-1:0] crc24q_byte(logic [CRC_BITS-1:0] crc,
                                                       logic [BYTE_BITS-1:0] b);
    logic [CRC_BITS-1:0] c;
    logic                msb;
    c = crc ^ {b, 16'h0000};
    for (int k = 0; k < BYTE_BITS; k++) begin
      msb = c[CRC_BITS-1];
      c = {c[CRC_BITS-2:0], 1'b0};
      if (msb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  task give_byte(input logic [BYTE_BITS-1:0] b, input logic closes);
    res_t r;
    pk_crc = crc24q_byte(pk_crc, b);
    r.out_byte    = b;
    r.byte_valid  = 1'b1;
    r.frame_end   = closes;
    r.last_of_run = 1'b0;
    beat_res_q = {beat_res_q, r};
  endtask

  task append_bits(input int w, input logic [FVALUE_W-1:0] v);
    for (int i = w - 1; i >= 0; i--) begin
      pk_byte[3'd7 - pk_pos] = v[i];
      if (pk_pos == 3'd7) begin
        give_byte(pk_byte, 1'b0);
        pk_byte = '0;
        pk_pos  = '0;
      end else begin
        pk_pos = pk_pos + 3'd1;
      end
    end
  endtask

  task flush_partial(input logic closes);
    if (pk_pos != '0) begin
      give_byte(pk_byte, closes);
      pk_byte = '0;
      pk_pos  = '0;
    end
  endtask

  task pack_beat(input logic [MODE_W-1:0] mode, input logic [FWIDTH_W-1:0] width,
                 input logic [FVALUE_W-1:0] value);
    int                  w;
    logic [FVALUE_W-1:0] v;
    logic [CRC_BITS-1:0] c;
    res_t                r;
    beat_res_q.delete();
    w = (int'(width) > FIELD_BITS_MAX) ? FIELD_BITS_MAX : int'(width);
    case (mode)
      MODE_UNSIGNED: begin
        append_bits(w, value);
      end
      MODE_SIGNED: begin
        if (w > 0) begin
          v = value;
          v[w-1] = value[FVALUE_W-1];
          append_bits(w, v);
        end
      end
      MODE_RAW: begin
        flush_partial(1'b0);
        give_byte(value[BYTE_BITS-1:0], 1'b0);
      end
      MODE_CRC: begin
        c = pk_crc;
        if (pk_pos != '0) c = crc24q_byte(c, pk_byte);
        append_bits(CRC_BITS, {{(FVALUE_W-CRC_BITS){1'b0}}, c});
      end
      MODE_END: begin
        if (pk_pos != '0) begin
          flush_partial(1'b1);
        end else begin
          r = '0;
          r.frame_end = 1'b1;
          beat_res_q = {beat_res_q, r};
        end
        pk_byte = '0;
        pk_pos  = '0;
        pk_crc  = '0;
      end
      default: ;
    endcase
    for (int i = 0; i < beat_res_q.size(); i++) begin
      r = beat_res_q[i];
      if (i == beat_res_q.size() - 1) r.last_of_run = 1'b1;
      byte_exp_q = {byte_exp_q, r};
    end
  endtask

  // ---------------------------------------------------------------- stimulus helpers
  function automatic logic [FVALUE_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [FWIDTH_W-1:0] rand_field_width();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return FWIDTH_W'(FIELD_BITS_MAX);
    if (r < 3) return FWIDTH_W'($urandom_range(17, FIELD_BITS_MAX - 1));
    return FWIDTH_W'($urandom_range(1, 16));
  endfunction

  task add_beat(input logic [MODE_W-1:0] mode, input int width,
                input logic [FVALUE_W-1:0] value);
    field_beat_t fb;
    fb.mode       = mode;
    fb.width      = FWIDTH_W'(width);
    fb.value      = value;
    fb.hold_first = 1'b0;
    pend_q = {pend_q, fb};
  endtask

  task flag_error(input string msg);
    if (err_cnt < MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------- input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.mode        <= '0;
      in_if.field_width <= '0;
      in_if.field_value <= '0;
      send_gap          <= 0;
      beats_taken       <= 0;
      quiet_tail        <= 1'b0;
      pk_byte = '0;
      pk_pos  = '0;
      pk_crc  = '0;
    end else begin
      quiet_tail <= (pend_q.size() <= TAIL_BEATS);
      if (in_if.valid && in_if.ready) begin
        pack_beat(in_if.mode, in_if.field_width, in_if.field_value);
        beats_taken <= beats_taken + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap != 0) begin
          in_if.valid <= 1'b0;
          send_gap    <= send_gap - 1;
        end else if (pend_q.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (pend_q[0].hold_first && byte_exp_q.size() != 0) begin
          in_if.valid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
          in_if.valid <= 1'b0;
          send_gap    <= $urandom_range(0, 17);
        end else begin
          in_if.valid       <= 1'b1;
          in_if.mode        <= pend_q[0].mode;
          in_if.field_width <= pend_q[0].width;
          in_if.field_value <= pend_q[0].value;
          void'(pend_q.pop_front());
        end
      end
    end
  end

  // ---------------------------------------------------------------- output ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready   <= 1'b0;
      stall_cnt      <= 0;
      long_hold_cnt  <= 0;
      long_hold_done <= 1'b0;
    end else if (!long_hold_done && beats_taken >= LONG_HOLD_AT) begin
      out_if.ready   <= 1'b0;
      long_hold_cnt  <= LONG_HOLD_CYCLES;
      long_hold_done <= 1'b1;
    end else if (long_hold_cnt != 0) begin
      out_if.ready  <= 1'b0;
      long_hold_cnt <= long_hold_cnt - 1;
    end else if (stall_cnt != 0) begin
      out_if.ready <= 1'b0;
      stall_cnt    <= stall_cnt - 1;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      out_if.ready <= 1'b0;
      stall_cnt    <= $urandom_range(0, 17);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- output checker
  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (byte_exp_q.size() == 0) begin
        flag_error($sformatf("unexpected beat: byte %02h vld %0b end %0b last %0b",
                             out_if.out_byte, out_if.byte_valid, out_if.frame_end,
                             out_if.last_of_run));
      end else begin
        exp_r = byte_exp_q.pop_front();
        if (out_if.out_byte !== exp_r.out_byte || out_if.byte_valid !== exp_r.byte_valid ||
            out_if.frame_end !== exp_r.frame_end ||
            out_if.last_of_run !== exp_r.last_of_run) begin
          flag_error($sformatf({"mismatch: exp byte %02h vld %0b end %0b last %0b,",
                                " got byte %02h vld %0b end %0b last %0b"},
                               exp_r.out_byte, exp_r.byte_valid, exp_r.frame_end,
                               exp_r.last_of_run, out_if.out_byte, out_if.byte_valid,
                               out_if.frame_end, out_if.last_of_run));
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    field_beat_t fb;
    int          n_fields;
    int          pick;
    in_if.valid       = 1'b0;
    in_if.mode        = '0;
    in_if.field_width = '0;
    in_if.field_value = '0;
    out_if.ready      = 1'b0;
    rst_ni            = 1'b0;
    err_cnt           = 0;

    add_beat(MODE_UNSIGNED, 1, 64'h1);
    add_beat(MODE_UNSIGNED, 64, '1);
    add_beat(MODE_UNSIGNED, 0, rand64());
    add_beat(MODE_UNSIGNED, 7, 64'h55);
    add_beat(MODE_SIGNED, 5, 64'h8000_0000_0000_0000);
    add_beat(MODE_SIGNED, 64, 64'h7FFF_FFFF_FFFF_FFFF);
    add_beat(MODE_SIGNED, 13, 64'h0000_0000_0000_1ABC);
    add_beat(MODE_UNSIGNED, 3, 64'h5);
    add_beat(MODE_RAW, 0, 64'hFFFF_FFFF_FFFF_FFA5);
    add_beat(MODE_RAW, 127, 64'h3C);
    add_beat(MODE_CRC, 0, '0);
    add_beat(MODE_UNSIGNED, 5, 64'h13);
    add_beat(MODE_CRC, 127, '1);
    add_beat(MODE_UNSIGNED, 3, 64'h6);
    add_beat(MODE_END, 0, '0);
    add_beat(MODE_END, 127, '1);
    add_beat(MODE_UNSIGNED, 127, rand64());
    add_beat(MODE_UNSIGNED, 65, rand64());
    add_beat(MODE_SIGNED, 100, rand64());
    add_beat(MODE_RSVD_LO, 127, '1);
    add_beat(MODE_RSVD_MID, 8, rand64());
    add_beat(MODE_RSVD_HI, 64, rand64());
    add_beat(MODE_SIGNED, 1, 64'h8000_0000_0000_0000);
    add_beat(MODE_SIGNED, 0, '1);
    add_beat(MODE_END, 0, '0);

    while (pend_q.size() < STIM_BEATS) begin
      n_fields = $urandom_range(1, 8);
      for (int k = 0; k < n_fields; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3)
          add_beat(MODE_W'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI)),
                   $urandom_range(0, 127), rand64());
        else if (pick < 6)
          add_beat((pick % 2) ? MODE_SIGNED : MODE_UNSIGNED,
                   (pick == 3) ? 0 : $urandom_range(FIELD_BITS_MAX + 1, 127), rand64());
        else if (pick < 16)
          add_beat(MODE_RAW, $urandom_range(0, 127), rand64());
        else
          add_beat((pick % 2) ? MODE_SIGNED : MODE_UNSIGNED, rand_field_width(), rand64());
      end
      if ($urandom_range(0, 9) != 0) begin
        if ($urandom_range(0, 3) != 0) add_beat(MODE_CRC, $urandom_range(0, 127), rand64());
        add_beat(MODE_END, $urandom_range(0, 127), rand64());
      end
    end
    fb = pend_q[PAUSE_BEAT];
    fb.hold_first = 1'b1;
    pend_q[PAUSE_BEAT] = fb;
    stim_total = pend_q.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_taken != stim_total) @(posedge clk_i);
    while (byte_exp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (byte_exp_q.size() != 0) flag_error("expected bytes never arrived");
    if (err_cnt == 0) begin
      $display("[msb_first_bit_packer_crc24q] OK");
    end else begin
      $display("[msb_first_bit_packer_crc24q] ERROR");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("[msb_first_bit_packer_crc24q] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/msbp_pkg.sv
design/msbp_if.sv
design/msbp_crc.sv
design/msbp_packer.sv
design/msbp_out_reg.sv
design/msb_first_bit_packer_crc24q.sv
tb/sv/tb_msb_first_bit_packer_crc24q.sv
